### hw/rtl/rlm_pkg.sv
`default_nettype none
package rlm_pkg;
    localparam int MaxFrameSamples = 4096;
    localparam logic [9:0] SystemGainReset = 10'd384;
    localparam logic [9:0] MicGainReset = 10'd512;
    localparam logic [15:0] MicGateReset = 16'd524;
    localparam logic [15:0] LevelFloorReset = 16'd328;
    localparam logic [15:0] CoefAttackOld = 16'd19661;
    localparam logic [15:0] CoefAttackNew = 16'd45875;
    localparam logic [15:0] CoefReleaseOld = 16'd52429;
    localparam logic [15:0] CoefReleaseNew = 16'd13107;
    localparam logic [15:0] CoefEmptyDecay = 16'd60293;
    localparam logic [15:0] CoefTickDecay = 16'd62259;
    localparam logic [15:0] ThreshOnePct = 16'd655;
    localparam logic [15:0] ThreshHalfPct = 16'd328;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_EMPTY  = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        REG_SYSTEM_GAIN = 2'd0,
        REG_MIC_GAIN    = 2'd1,
        REG_MIC_GATE    = 2'd2,
        REG_LEVEL_FLOOR = 2'd3
    } t_reg_idx;

    // command handed from front to back
    typedef struct packed {
        t_opcode     op;
        logic        src;
        logic [42:0] sum;
        logic [16:0] count;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_SQRT1, ST_SQRT2, ST_GAIN, ST_MIX1, ST_MIX2,
        ST_MIX3, ST_DECAY, ST_DONE
    } t_state;
endpackage
`default_nettype wire

### hw/rtl/rms_level_meter.sv
`default_nettype none
// Two-source audio level meter. Items enter through a push/full queue port; a
// sample is accumulated in a register, so samples stream at one per cycle
// while the command queue is not full. A frame end (sample with last), an
// empty frame or a tick becomes a command in a four-entry queue that a
// sequential back end works off: a 43-step divider, two radix-4 square roots,
// gain and smoothing per frame end, a decay update per empty frame or tick.
// Results (both levels) wait in a four-entry output queue. Opcode 3 is ignored.
module rms_level_meter #(
    parameter int MAX_FRAME_SAMPLES = rlm_pkg::MaxFrameSamples
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_opcode,
    input  wire logic        i_source,
    input  wire logic [15:0] i_sample,
    input  wire logic        i_last,
    output logic             empty,
    input  wire logic        pop,
    output logic [15:0]      o_system_level,
    output logic [15:0]      o_mic_level,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [9:0]  r_system_gain, r_mic_gain;
    logic [15:0] r_mic_gate, r_level_floor;
    logic        cfg_wr;
    logic        cq_push, cq_full, cq_empty, cq_pop;
    rlm_pkg::t_cmd cq_in, cq_out;
    logic        rq_push, rq_full;
    logic [31:0] rq_in, rq_out;
    logic        front_ready, back_busy;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_system_gain <= rlm_pkg::SystemGainReset;
            r_mic_gain    <= rlm_pkg::MicGainReset;
            r_mic_gate    <= rlm_pkg::MicGateReset;
            r_level_floor <= rlm_pkg::LevelFloorReset;
        end else if (cfg_wr) begin
            unique case (rlm_pkg::t_reg_idx'(paddr[3:2]))
                rlm_pkg::REG_SYSTEM_GAIN: r_system_gain <= pwdata[9:0];
                rlm_pkg::REG_MIC_GAIN:    r_mic_gain    <= pwdata[9:0];
                rlm_pkg::REG_MIC_GATE:    r_mic_gate    <= pwdata[15:0];
                rlm_pkg::REG_LEVEL_FLOOR: r_level_floor <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (rlm_pkg::t_reg_idx'(paddr[3:2]))
            rlm_pkg::REG_SYSTEM_GAIN: prdata = {22'd0, r_system_gain};
            rlm_pkg::REG_MIC_GAIN:    prdata = {22'd0, r_mic_gain};
            rlm_pkg::REG_MIC_GATE:    prdata = {16'd0, r_mic_gate};
            rlm_pkg::REG_LEVEL_FLOOR: prdata = {16'd0, r_level_floor};
            default: prdata = '0;
        endcase
    end

    assign full = !front_ready;

    rlm_front #(.MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES)) u_front (
        .i_clk, .i_rst_n, .i_valid(push), .i_opcode, .i_source, .i_sample,
        .i_last, .i_q_full(cq_full), .o_ready(front_ready), .o_push(cq_push),
        .o_cmd(cq_in)
    );

    rlm_queue #(.Width($bits(rlm_pkg::t_cmd)), .Depth(4)) u_cmd_q (
        .i_clk, .i_rst_n, .i_push(cq_push), .i_data(cq_in), .i_pop(cq_pop),
        .o_full(cq_full), .o_empty(cq_empty), .o_data(cq_out)
    );

    rlm_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(!cq_empty), .i_cmd(cq_out),
        .o_cmd_pop(cq_pop), .i_system_gain(r_system_gain),
        .i_mic_gain(r_mic_gain), .i_mic_gate(r_mic_gate),
        .i_level_floor(r_level_floor), .i_res_full(rq_full),
        .o_res_push(rq_push), .o_res_data(rq_in), .o_busy(back_busy)
    );

    rlm_queue #(.Width(32), .Depth(4)) u_res_q (
        .i_clk, .i_rst_n, .i_push(rq_push), .i_data(rq_in), .i_pop(pop),
        .o_full(rq_full), .o_empty(empty), .o_data(rq_out)
    );

    assign o_system_level = rq_out[15:0];
    assign o_mic_level    = rq_out[31:16];

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rq_push && rq_full)) else $error("result pushed into full queue");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cq_pop |-> !$past(back_busy) || $past(rq_push))
        else $error("command taken while back end busy");
    a_push_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rq_push |=> !back_busy) else $error("back end still busy after result");
endmodule
`default_nettype wire

### hw/rtl/rlm_front.sv
`default_nettype none
module rlm_front #(
    parameter int MAX_FRAME_SAMPLES = rlm_pkg::MaxFrameSamples,
    localparam int CntW = $clog2(MAX_FRAME_SAMPLES + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [1:0]    i_opcode,
    input  wire logic          i_source,
    input  wire logic [15:0]   i_sample,
    input  wire logic          i_last,
    input  wire logic          i_q_full,
    output logic               o_ready,
    output logic               o_push,
    output rlm_pkg::t_cmd      o_cmd
);
    logic [42:0]     r_sum [2];
    logic [CntW-1:0] r_cnt [2];
    logic [15:0]     mag;
    logic [31:0]     sq;
    logic            room;
    logic [42:0]     sum_new;
    logic [CntW-1:0] cnt_new;
    logic            accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign mag  = i_sample[15] ? 16'(-i_sample) : i_sample;
    assign sq   = mag * mag;
    assign room = r_cnt[i_source] < CntW'(MAX_FRAME_SAMPLES);
    assign sum_new = room ? r_sum[i_source] + 43'(sq) : r_sum[i_source];
    assign cnt_new = room ? r_cnt[i_source] + CntW'(1) : r_cnt[i_source];

    always_comb begin
        o_push = 1'b0;
        o_cmd.op    = rlm_pkg::t_opcode'(i_opcode);
        o_cmd.src   = i_source;
        o_cmd.sum   = sum_new;
        o_cmd.count = 17'(cnt_new);
        if (accept) begin
            unique case (rlm_pkg::t_opcode'(i_opcode))
                rlm_pkg::OP_SAMPLE: o_push = i_last;
                rlm_pkg::OP_EMPTY, rlm_pkg::OP_TICK: o_push = 1'b1;
                default: o_push = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum[0] <= '0; r_sum[1] <= '0;
            r_cnt[0] <= '0; r_cnt[1] <= '0;
        end else if (accept) begin
            if (rlm_pkg::t_opcode'(i_opcode) == rlm_pkg::OP_SAMPLE) begin
                r_sum[i_source] <= i_last ? '0 : sum_new;
                r_cnt[i_source] <= i_last ? '0 : cnt_new;
            end else if (rlm_pkg::t_opcode'(i_opcode) == rlm_pkg::OP_EMPTY) begin
                r_sum[i_source] <= '0;
                r_cnt[i_source] <= '0;
            end
        end
    end
endmodule
`default_nettype wire

### hw/rtl/rlm_queue.sv
`default_nettype none
module rlm_queue #(
    parameter int Width = 8,
    parameter int Depth = 4,
    localparam int AW = $clog2(Depth)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [Width-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output logic [Width-1:0]      o_data
);
    logic [Width-1:0] r_mem [Depth];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt;
    logic             do_push, do_pop;

    assign o_full  = r_cnt == (AW+1)'(Depth);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == AW'(Depth-1)) ? '0 : r_wr + AW'(1);
            if (do_pop)  r_rd <= (r_rd == AW'(Depth-1)) ? '0 : r_rd + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end
endmodule
`default_nettype wire

### hw/rtl/rlm_back.sv
`default_nettype none
module rlm_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    input  rlm_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    input  wire logic [9:0]    i_system_gain,
    input  wire logic [9:0]    i_mic_gain,
    input  wire logic [15:0]   i_mic_gate,
    input  wire logic [15:0]   i_level_floor,
    input  wire logic          i_res_full,
    output logic               o_res_push,
    output logic [31:0]        o_res_data,
    output logic               o_busy
);
    rlm_pkg::t_state r_state, n_state;
    rlm_pkg::t_cmd   r_cmd;
    logic [15:0] r_level [2];
    logic [42:0] r_rem;     // dividend remainder / isqrt operand
    logic [42:0] r_quo;     // quotient / root
    logic [43:0] r_bit;
    logic [5:0]  r_step;
    logic [16:0] r_rms;
    logic [33:0] r_prod_a, r_prod_b;
    logic [16:0] r_raw;
    logic        ld_cmd;

    // restoring divider step
    logic [43:0] div_trial;
    logic [42:0] div_rem_sh;
    logic [42:0] div_q;
    logic [42:0] div_r;
    // isqrt step
    logic [44:0] sq_trial;
    logic [15:0] cur;
    logic [26:0] gprod;
    logic [9:0]  gain;
    logic [34:0] mix_sum;
    logic [15:0] dec_in;
    logic [32:0] dec_prod;
    logic [16:0] dec_val;
    logic [15:0] dec_thr;

    assign cur  = r_level[r_cmd.src];
    assign gain = r_cmd.src ? i_mic_gain : i_system_gain;
    assign div_rem_sh = {r_rem[41:0], r_quo[42]};
    assign div_trial  = {1'b0, div_rem_sh} - {27'd0, r_cmd.count};
    assign div_q      = {r_quo[41:0], !div_trial[43]};
    assign div_r      = div_trial[43] ? div_rem_sh : div_trial[42:0];
    assign sq_trial   = {2'b0, r_rem} - ({2'b0, r_quo} + {1'b0, r_bit});
    assign gprod   = r_quo[16:0] * gain;
    assign mix_sum = 35'(r_prod_a) + 35'(r_prod_b) + 35'd32768;
    // a tick always works on the microphone level
    assign dec_in   = (r_cmd.op == rlm_pkg::OP_EMPTY) ? cur : r_level[1];
    assign dec_prod = dec_in * ((r_cmd.op == rlm_pkg::OP_EMPTY) ?
                      rlm_pkg::CoefEmptyDecay : rlm_pkg::CoefTickDecay);
    assign dec_val = 17'((33'(dec_prod) + 33'd32768) >> 16);
    assign dec_thr = (r_cmd.op == rlm_pkg::OP_EMPTY) ? rlm_pkg::ThreshOnePct
                                                     : rlm_pkg::ThreshHalfPct;
    assign o_busy = r_state != rlm_pkg::ST_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd_pop = 1'b0;
        o_res_push = 1'b0;
        ld_cmd = 1'b0;
        o_res_data = {r_level[1], r_level[0]};
        unique case (r_state)
            rlm_pkg::ST_IDLE: if (i_cmd_valid) begin
                o_cmd_pop = 1'b1; ld_cmd = 1'b1;
                n_state = (i_cmd.op == rlm_pkg::OP_SAMPLE) ? rlm_pkg::ST_DIV
                                                           : rlm_pkg::ST_DECAY;
            end
            rlm_pkg::ST_DIV:   if (r_step == 6'd42) n_state = rlm_pkg::ST_SQRT1;
            rlm_pkg::ST_SQRT1: if (r_bit == 44'd0) n_state = rlm_pkg::ST_SQRT2;
            rlm_pkg::ST_SQRT2: if (r_bit == 44'd0) n_state = rlm_pkg::ST_GAIN;
            rlm_pkg::ST_GAIN:  n_state = rlm_pkg::ST_MIX1;
            rlm_pkg::ST_MIX1:  n_state = rlm_pkg::ST_MIX2;
            rlm_pkg::ST_MIX2:  n_state = rlm_pkg::ST_MIX3;
            rlm_pkg::ST_MIX3:  n_state = rlm_pkg::ST_DONE;
            rlm_pkg::ST_DECAY: n_state = rlm_pkg::ST_DONE;
            rlm_pkg::ST_DONE: if (!i_res_full) begin
                o_res_push = 1'b1;
                n_state = rlm_pkg::ST_IDLE;
            end
            default: n_state = rlm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rlm_pkg::ST_IDLE;
            r_level[0] <= '0; r_level[1] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == rlm_pkg::ST_MIX3)
                r_level[r_cmd.src] <= mix_sum[34:32] != 3'd0 ? 16'hFFFF : mix_sum[31:16];
            if (r_state == rlm_pkg::ST_DECAY) begin
                if (r_cmd.op == rlm_pkg::OP_EMPTY)
                    r_level[r_cmd.src] <= (dec_val < 17'(dec_thr)) ? '0 : dec_val[15:0];
                else if (r_level[1] > rlm_pkg::ThreshOnePct)
                    r_level[1] <= (dec_val < 17'(dec_thr)) ? '0 : dec_val[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_cmd) begin
            r_cmd <= i_cmd;
            r_rem <= '0;
            r_quo <= i_cmd.sum;
            r_step <= '0;
        end
        unique case (r_state)
            rlm_pkg::ST_DIV: begin
                // quotient bits shift into r_quo from the right
                r_step <= r_step + 6'd1;
                if (r_step == 6'd42) begin
                    // mean * 4 is the operand of the first root
                    r_rem <= {div_q[40:0], 2'b00};
                    r_quo <= '0;
                    r_bit <= 44'd1 << 42;
                end else begin
                    r_rem <= div_r;
                    r_quo <= div_q;
                end
            end
            rlm_pkg::ST_SQRT1, rlm_pkg::ST_SQRT2: begin
                if (r_bit != 44'd0) begin
                    if (!sq_trial[44]) begin
                        r_rem <= sq_trial[42:0];
                        r_quo <= 43'((r_quo >> 1) + 43'(r_bit));
                    end else begin
                        r_quo <= r_quo >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end else if (r_state == rlm_pkg::ST_SQRT1) begin
                    r_rms <= r_quo[16:0];
                    r_rem <= {9'd0, r_quo[17:0], 16'd0};
                    r_quo <= '0;
                    r_bit <= 44'd1 << 42;
                end
            end
            rlm_pkg::ST_GAIN: begin
                if (r_cmd.src && r_rms < 17'(i_mic_gate))
                    r_raw <= '0;
                else
                    r_raw <= (gprod[26:8] > 19'd65535) ? 17'd65535 : 17'(gprod[26:8]);
            end
            rlm_pkg::ST_MIX1: if (r_raw < 17'(i_level_floor)) r_raw <= '0;
            rlm_pkg::ST_MIX2: begin
                if (r_raw > 17'(cur)) begin
                    r_prod_a <= 34'(cur) * 34'(rlm_pkg::CoefAttackOld);
                    r_prod_b <= 34'(r_raw) * 34'(rlm_pkg::CoefAttackNew);
                end else begin
                    r_prod_a <= 34'(cur) * 34'(rlm_pkg::CoefReleaseOld);
                    r_prod_b <= 34'(r_raw) * 34'(rlm_pkg::CoefReleaseNew);
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

### tb/sv/rms_level_meter_tb.sv
module rms_level_meter_tb;
    import rlm_pkg::*;

    class level_board;
        bit [9:0]  sys_gain;
        bit [9:0]  mic_gain;
        bit [15:0] mic_gate;
        bit [15:0] floor_lvl;
        bit [42:0] sq_sum[2];
        bit [12:0] cnt[2];
        bit [15:0] lvl[2];
        bit [31:0] pending[$];
        int        errors;

        function new();
            sys_gain = SystemGainReset;
            mic_gain = MicGainReset;
            mic_gate = MicGateReset;
            floor_lvl = LevelFloorReset;
            for (int s = 0; s < 2; s++) begin
                sq_sum[s] = 0;
                cnt[s] = 0;
                lvl[s] = 0;
            end
            errors = 0;
        endfunction

        function void set_reg(t_reg_idx idx, bit [31:0] v);
            case (idx)
                REG_SYSTEM_GAIN: sys_gain = v[9:0];
                REG_MIC_GAIN:    mic_gain = v[9:0];
                REG_MIC_GATE:    mic_gate = v[15:0];
                REG_LEVEL_FLOOR: floor_lvl = v[15:0];
            endcase
        endfunction

        function bit [63:0] int_sqrt(bit [63:0] v);
            bit [63:0] res;
            bit [63:0] b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function bit [15:0] scale(bit [15:0] v, bit [15:0] c);
            bit [63:0] p;
            p = (64'(v) * c + 32768) >> 16;
            return p[15:0];
        endfunction

        function void close_frame(int s);
            bit [63:0] n, mean, rms, root, raw, mixed, g;
            n = (cnt[s] != 0) ? 64'(cnt[s]) : 64'd1;
            mean = 64'(sq_sum[s]) / n;
            rms = int_sqrt(mean << 2);
            root = int_sqrt(rms << 16);
            g = s ? 64'(mic_gain) : 64'(sys_gain);
            raw = (root * g) >> 8;
            if (raw > 65535) raw = 65535;
            if (s == 1 && rms < mic_gate) raw = 0;
            if (raw < floor_lvl) raw = 0;
            if (raw > lvl[s])
                mixed = 64'(lvl[s]) * CoefAttackOld + raw * CoefAttackNew;
            else
                mixed = 64'(lvl[s]) * CoefReleaseOld + raw * CoefReleaseNew;
            mixed = (mixed + 32768) >> 16;
            if (mixed > 65535) mixed = 65535;
            lvl[s] = mixed[15:0];
            sq_sum[s] = 0;
            cnt[s] = 0;
        endfunction

        function void note_item(bit [1:0] op, bit s, bit [15:0] smp, bit lst);
            bit [15:0] d;
            bit [31:0] mag;
            case (t_opcode'(op))
                OP_SAMPLE: begin
                    if (cnt[s] < MaxFrameSamples) begin
                        mag = smp[15] ? (32'd65536 - smp) : 32'(smp);
                        sq_sum[s] += 43'(mag * mag);
                        cnt[s] += 1;
                    end
                    if (!lst) return;
                    close_frame(s);
                end
                OP_EMPTY: begin
                    d = scale(lvl[s], CoefEmptyDecay);
                    if (d < ThreshOnePct) d = 0;
                    lvl[s] = d;
                    sq_sum[s] = 0;
                    cnt[s] = 0;
                end
                OP_TICK: begin
                    if (lvl[1] > ThreshOnePct) begin
                        d = scale(lvl[1], CoefTickDecay);
                        if (d < ThreshHalfPct) d = 0;
                        lvl[1] = d;
                    end
                end
                default: return;
            endcase
            pending.push_back({lvl[0], lvl[1]});
        endfunction

        function void check_levels(bit [15:0] sys, bit [15:0] mic);
            bit [31:0] e;
            if (pending.size() == 0) begin
                $error("unexpected result sys=%0d mic=%0d", sys, mic);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e[31:16] !== sys) begin
                $error("system_level expected %0d actual %0d", e[31:16], sys);
                errors++;
            end
            if (e[15:0] !== mic) begin
                $error("mic_level expected %0d actual %0d", e[15:0], mic);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        push = 0;
    logic [1:0]  opcode = 0;
    logic        source = 0;
    logic [15:0] sample = 0;
    logic        last = 0;
    logic        pop = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic        full, empty, pready;
    logic [15:0] sys_level, mic_level;
    logic [31:0] prdata;

    level_board board = new();
    bit calm = 0;
    int hold_cycles = 0;
    bit stim_done = 0;

    rms_level_meter u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .push(push), .full(full),
        .i_opcode(opcode), .i_source(source), .i_sample(sample), .i_last(last),
        .empty(empty), .pop(pop),
        .o_system_level(sys_level), .o_mic_level(mic_level),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #2 clk = 1;
        #2 clk = 0;
    end

    // result side: checks at the edge, random pops, one long hold-off on request
    always @(posedge clk) begin
        if (rst_n && pop && !empty) board.check_levels(sys_level, mic_level);
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            pop <= 0;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
            hold_cycles <= $urandom_range(1, 15);
            pop <= 0;
        end else begin
            pop <= 1;
        end
    end

    // push stays high between back-to-back items; drain() lowers it
    task automatic send_item(bit [1:0] op, bit s, bit [15:0] smp, bit lst);
        int gap;
        if (!calm && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 15);
            push <= 0;
            repeat (gap) @(posedge clk);
        end
        push <= 1;
        opcode <= op;
        source <= s;
        sample <= smp;
        last <= lst;
        @(posedge clk);
        while (full) @(posedge clk);
        board.note_item(op, s, smp, lst);
    endtask

    task automatic write_reg(t_reg_idx idx, bit [31:0] v);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= 4'(idx) << 2;
        pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        board.set_reg(idx, v);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        push <= 0;
        while (board.pending.size() != 0 && guard < 200000) begin
            @(posedge clk);
            guard++;
        end
        repeat (200) @(posedge clk);
    endtask

    task automatic send_frame(bit s, int n, int amp);
        for (int k = 0; k < n; k++)
            send_item(OP_SAMPLE, s, 16'($urandom_range(0, amp) *
                      (($urandom_range(0, 1)) ? -1 : 1)), k == n - 1);
    endtask

    task automatic random_phase(int items);
        int done;
        int n;
        done = 0;
        while (done < items) begin
            case ($urandom_range(0, 9))
                0: begin send_item(OP_EMPTY, $urandom_range(0, 1), $urandom, $urandom); done++; end
                1: begin send_item(OP_TICK, $urandom_range(0, 1), $urandom, $urandom); done++; end
                2: send_item(OP_NONE, $urandom, $urandom, $urandom);
                3: begin
                    send_item(OP_SAMPLE, $urandom, $urandom, $urandom);
                    done++;
                end
                default: begin
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64)
                                                    : $urandom_range(1, 12);
                    send_frame($urandom_range(0, 1), n,
                               ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(0, 4000));
                    done += n;
                end
            endcase
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, every opcode, gating and floor, empty mid-frame
        send_item(OP_SAMPLE, 0, 16'h8000, 0);
        send_item(OP_SAMPLE, 0, 16'h7fff, 1);
        send_item(OP_SAMPLE, 1, 16'h8000, 1);
        send_item(OP_SAMPLE, 1, 16'h0001, 1);
        send_item(OP_SAMPLE, 0, 16'h0000, 1);
        send_item(OP_TICK, 0, 16'hffff, 1);
        send_item(OP_TICK, 1, 16'h0000, 0);
        send_item(OP_SAMPLE, 1, 16'h1234, 0);
        send_item(OP_EMPTY, 1, 16'h0000, 0);
        send_item(OP_EMPTY, 0, 16'hffff, 1);
        send_item(OP_NONE, 1, 16'hffff, 1);
        send_item(OP_SAMPLE, 0, 16'h0100, 1);
        send_item(OP_EMPTY, 1, 16'h0000, 0);
        drain();

        // frame overflow: more samples than the frame holds
        for (int k = 0; k < MaxFrameSamples + 3; k++)
            send_item(OP_SAMPLE, 1, k < MaxFrameSamples ? 16'h0010 : 16'h7fff,
                      k == MaxFrameSamples + 2);
        drain();

        write_reg(REG_SYSTEM_GAIN, 1023);
        write_reg(REG_MIC_GAIN, 1023);
        write_reg(REG_MIC_GATE, 0);
        write_reg(REG_LEVEL_FLOOR, 0);
        random_phase(300);
        drain();

        // stall the receiver while items keep coming
        @(negedge clk);
        hold_cycles = 400;
        @(posedge clk);
        random_phase(200);
        drain();

        write_reg(REG_SYSTEM_GAIN, 0);
        write_reg(REG_MIC_GAIN, 0);
        write_reg(REG_MIC_GATE, 65535);
        write_reg(REG_LEVEL_FLOOR, 65535);
        random_phase(150);
        drain();

        write_reg(REG_SYSTEM_GAIN, $urandom_range(0, 1023));
        write_reg(REG_MIC_GAIN, $urandom_range(0, 1023));
        write_reg(REG_MIC_GATE, $urandom_range(0, 3000));
        write_reg(REG_LEVEL_FLOOR, $urandom_range(0, 3000));
        random_phase(500);
        drain();

        calm = 1;
        write_reg(REG_SYSTEM_GAIN, SystemGainReset);
        write_reg(REG_MIC_GAIN, MicGainReset);
        write_reg(REG_MIC_GATE, MicGateReset);
        write_reg(REG_LEVEL_FLOOR, LevelFloorReset);
        random_phase(300);
        drain();

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            if (board.pending.size() != 0)
                $error("%0d results never arrived", board.pending.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

### rms_level_meter.f
hw/rtl/rlm_pkg.sv
hw/rtl/rlm_front.sv
hw/rtl/rlm_queue.sv
hw/rtl/rlm_back.sv
hw/rtl/rms_level_meter.sv
tb/sv/rms_level_meter_tb.sv
